// ----- rtl/ale_pkg.sv -----
// Shared types and constants for the assembly line encoder.
// Used by ale_mnem_dec, ale_line_core and assembly_line_encoder; no dependencies.
package ale_pkg;

  // Widest address value the A-instruction accepts is 2^ADDRESS_BITS - 1.
  localparam int ADDRESS_BITS = 15;
  localparam int ACC_W        = 16;
  localparam int PROD_W       = ACC_W + 4;
  localparam logic [PROD_W-1:0] ADDR_LIMIT = PROD_W'((1 << ADDRESS_BITS) - 1);

  localparam int TOK_W = 24;
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] TOK_FULL = 3'd3;
  localparam logic [CNT_W-1:0] TOK_OVER = 3'd4;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_SLASH = "/";
  localparam logic [7:0] CH_AT    = "@";
  localparam logic [7:0] CH_EQ    = "=";
  localparam logic [7:0] CH_SEMI  = ";";
  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_NINE  = "9";

  typedef enum logic [2:0] {
    PH_START,
    PH_ADDR,
    PH_FIRST,
    PH_COMP,
    PH_JUMP,
    PH_CMT_NONE,
    PH_CMT_WORD
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_MALFORMED,
    ERR_OVERFLOW,
    ERR_SLASH
  } line_err_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // Mnemonic table hits for the current token.
  typedef struct packed {
    logic       comp_hit;
    logic [6:0] comp_code;
    logic       dest_hit;
    logic [2:0] dest_code;
    logic       jump_hit;
    logic [2:0] jump_code;
  } lookup_t;

  // One finished line from the core.
  typedef struct packed {
    logic        emit;
    logic [15:0] word;
    status_e     status;
  } line_res_t;

endpackage

// ----- rtl/ale_mnem_dec.sv -----
// Mnemonic decoder: matches the current token against the comp, dest and jump tables.
// Depends on ale_pkg.
module ale_mnem_dec
  import ale_pkg::*;
(
  input  logic [TOK_W-1:0] tok_chars_i,
  input  logic [CNT_W-1:0] tok_cnt_i,
  output lookup_t          lookup_o
);

  logic [CNT_W+TOK_W-1:0] key;

  assign key = {tok_cnt_i, tok_chars_i};

  always_comb begin
    lookup_o = '0;
    lookup_o.comp_hit = 1'b1;
    case (key)
      {3'd1, 16'h0, "0"}: lookup_o.comp_code = 7'h2A;
      {3'd1, 16'h0, "1"}: lookup_o.comp_code = 7'h3F;
      {3'd2, 8'h0, "-1"}: lookup_o.comp_code = 7'h3A;
      {3'd1, 16'h0, "D"}: lookup_o.comp_code = 7'h0C;
      {3'd1, 16'h0, "A"}: lookup_o.comp_code = 7'h30;
      {3'd2, 8'h0, "!D"}: lookup_o.comp_code = 7'h0D;
      {3'd2, 8'h0, "!A"}: lookup_o.comp_code = 7'h31;
      {3'd2, 8'h0, "-D"}: lookup_o.comp_code = 7'h0F;
      {3'd2, 8'h0, "-A"}: lookup_o.comp_code = 7'h33;
      {3'd3, "D+1"}:      lookup_o.comp_code = 7'h1F;
      {3'd3, "A+1"}:      lookup_o.comp_code = 7'h37;
      {3'd3, "D-1"}:      lookup_o.comp_code = 7'h0E;
      {3'd3, "A-1"}:      lookup_o.comp_code = 7'h32;
      {3'd3, "D+A"}:      lookup_o.comp_code = 7'h02;
      {3'd3, "D-A"}:      lookup_o.comp_code = 7'h13;
      {3'd3, "A-D"}:      lookup_o.comp_code = 7'h07;
      {3'd3, "D&A"}:      lookup_o.comp_code = 7'h00;
      {3'd3, "D|A"}:      lookup_o.comp_code = 7'h15;
      {3'd1, 16'h0, "M"}: lookup_o.comp_code = 7'h70;
      {3'd2, 8'h0, "!M"}: lookup_o.comp_code = 7'h71;
      {3'd2, 8'h0, "-M"}: lookup_o.comp_code = 7'h73;
      {3'd3, "M+1"}:      lookup_o.comp_code = 7'h77;
      {3'd3, "M-1"}:      lookup_o.comp_code = 7'h72;
      {3'd3, "D+M"}:      lookup_o.comp_code = 7'h42;
      {3'd3, "D-M"}:      lookup_o.comp_code = 7'h53;
      {3'd3, "M-D"}:      lookup_o.comp_code = 7'h47;
      {3'd3, "D&M"}:      lookup_o.comp_code = 7'h40;
      {3'd3, "D|M"}:      lookup_o.comp_code = 7'h55;
      default:            lookup_o.comp_hit  = 1'b0;
    endcase

    lookup_o.dest_hit = 1'b1;
    case (key)
      {3'd1, 16'h0, "M"}: lookup_o.dest_code = 3'd1;
      {3'd1, 16'h0, "D"}: lookup_o.dest_code = 3'd2;
      {3'd2, 8'h0, "MD"}: lookup_o.dest_code = 3'd3;
      {3'd1, 16'h0, "A"}: lookup_o.dest_code = 3'd4;
      {3'd2, 8'h0, "AM"}: lookup_o.dest_code = 3'd5;
      {3'd2, 8'h0, "AD"}: lookup_o.dest_code = 3'd6;
      {3'd3, "AMD"}:      lookup_o.dest_code = 3'd7;
      default:            lookup_o.dest_hit  = 1'b0;
    endcase

    lookup_o.jump_hit = 1'b1;
    case (key)
      {3'd3, "JGT"}: lookup_o.jump_code = 3'd1;
      {3'd3, "JEQ"}: lookup_o.jump_code = 3'd2;
      {3'd3, "JGE"}: lookup_o.jump_code = 3'd3;
      {3'd3, "JLT"}: lookup_o.jump_code = 3'd4;
      {3'd3, "JNE"}: lookup_o.jump_code = 3'd5;
      {3'd3, "JLE"}: lookup_o.jump_code = 3'd6;
      {3'd3, "JMP"}: lookup_o.jump_code = 3'd7;
      default:       lookup_o.jump_hit  = 1'b0;
    endcase
  end

endmodule

// ----- rtl/ale_line_core.sv -----
// Line state machine: parses one character per step and finishes a line on newline.
// Depends on ale_pkg and ale_mnem_dec.
module ale_line_core
  import ale_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic [7:0] ch_i,
  output line_res_t res_o
);

  phase_e            phase_q, phase_d;
  line_err_e         err_q, err_d;
  logic [TOK_W-1:0]  tok_chars_q, tok_chars_d;
  logic [CNT_W-1:0]  tok_cnt_q, tok_cnt_d;
  logic [ACC_W-1:0]  accum_q, accum_d;
  logic [2:0]        dest_q, dest_d;
  logic [6:0]        comp_q, comp_d;

  lookup_t           lk;
  logic [15:0]       fin_word;
  status_e           fin_st;
  logic              is_digit;
  logic [PROD_W-1:0] prod;
  phase_e            eff_phase;

  ale_mnem_dec u_dec (
    .tok_chars_i (tok_chars_q),
    .tok_cnt_i   (tok_cnt_q),
    .lookup_o    (lk)
  );

  assign is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign prod = ({4'b0, accum_q} << 3) + ({4'b0, accum_q} << 1) + PROD_W'(ch_i - CH_ZERO);
  assign eff_phase = (phase_q == PH_START) ? PH_FIRST : phase_q;

  // Word and status if the line were closed now.
  always_comb begin
    fin_word = '0;
    fin_st   = ST_OK;
    unique case (phase_q)
      PH_ADDR: begin
        if (tok_cnt_q == '0) fin_st = ST_MALFORMED;
        else fin_word = accum_q;
      end
      PH_FIRST, PH_COMP: begin
        if (!lk.comp_hit) fin_st = ST_MALFORMED;
        else fin_word = {3'b111, lk.comp_code,
                         (phase_q == PH_FIRST) ? 3'b000 : dest_q, 3'b000};
      end
      PH_JUMP: begin
        if (!lk.jump_hit) fin_st = ST_MALFORMED;
        else fin_word = {3'b111, comp_q, dest_q, lk.jump_code};
      end
      default: fin_st = ST_MALFORMED;
    endcase
  end

  // Result of a newline.
  always_comb begin
    res_o = '0;
    res_o.status = ST_OK;
    if (step_i && ch_i == CH_NL) begin
      if (err_q == ERR_SLASH) begin
        res_o.emit   = 1'b1;
        res_o.status = ST_MALFORMED;
      end else if (err_q == ERR_MALFORMED) begin
        res_o.emit   = 1'b1;
        res_o.status = ST_MALFORMED;
      end else if (err_q == ERR_OVERFLOW) begin
        res_o.emit   = 1'b1;
        res_o.status = ST_OVERFLOW;
      end else if (phase_q == PH_CMT_WORD) begin
        res_o.emit = 1'b1;
        res_o.word = accum_q;
      end else if (phase_q != PH_START && phase_q != PH_CMT_NONE) begin
        res_o.emit   = 1'b1;
        res_o.status = fin_st;
        res_o.word   = (fin_st == ST_OK) ? fin_word : 16'h0;
      end
    end
  end

  // Next state.
  always_comb begin
    phase_d     = phase_q;
    err_d       = err_q;
    tok_chars_d = tok_chars_q;
    tok_cnt_d   = tok_cnt_q;
    accum_d     = accum_q;
    dest_d      = dest_q;
    comp_d      = comp_q;
    if (!step_i) begin
      // hold
    end else if (ch_i == CH_NL) begin
      phase_d     = PH_START;
      err_d       = ERR_NONE;
      tok_chars_d = '0;
      tok_cnt_d   = '0;
      accum_d     = '0;
      dest_d      = '0;
      comp_d      = '0;
    end else if (ch_i == CH_SP || ch_i == CH_CR) begin
      // drop
    end else if (phase_q == PH_CMT_NONE || phase_q == PH_CMT_WORD) begin
      // drop comment text
    end else if (err_q == ERR_MALFORMED || err_q == ERR_OVERFLOW) begin
      // drop until newline
    end else if (err_q == ERR_SLASH) begin
      if (ch_i == CH_SLASH) begin
        err_d = ERR_NONE;
        if (phase_q == PH_START) begin
          phase_d = PH_CMT_NONE;
        end else if (fin_st != ST_OK) begin
          err_d = ERR_MALFORMED;
        end else begin
          accum_d = fin_word;
          phase_d = PH_CMT_WORD;
        end
      end else begin
        err_d = ERR_MALFORMED;
      end
    end else if (ch_i == CH_SLASH) begin
      err_d = ERR_SLASH;
    end else if (phase_q == PH_START && ch_i == CH_AT) begin
      phase_d = PH_ADDR;
    end else begin
      phase_d = eff_phase;
      unique case (eff_phase)
        PH_ADDR: begin
          if (is_digit) begin
            tok_cnt_d = 3'd1;
            if (prod > ADDR_LIMIT) err_d = ERR_OVERFLOW;
            else accum_d = prod[ACC_W-1:0];
          end else begin
            err_d = ERR_MALFORMED;
          end
        end
        PH_FIRST, PH_COMP: begin
          if (ch_i == CH_EQ) begin
            if (eff_phase == PH_FIRST && lk.dest_hit) begin
              dest_d      = lk.dest_code;
              tok_chars_d = '0;
              tok_cnt_d   = '0;
              phase_d     = PH_COMP;
            end else begin
              err_d = ERR_MALFORMED;
            end
          end else if (ch_i == CH_SEMI) begin
            if (lk.comp_hit) begin
              comp_d      = lk.comp_code;
              if (eff_phase == PH_FIRST) dest_d = '0;
              tok_chars_d = '0;
              tok_cnt_d   = '0;
              phase_d     = PH_JUMP;
            end else begin
              err_d = ERR_MALFORMED;
            end
          end else if (tok_cnt_q < TOK_FULL) begin
            tok_chars_d = {tok_chars_q[TOK_W-9:0], ch_i};
            tok_cnt_d   = tok_cnt_q + 3'd1;
          end else begin
            tok_cnt_d = TOK_OVER;
          end
        end
        PH_JUMP: begin
          if (ch_i == CH_EQ || ch_i == CH_SEMI) begin
            err_d = ERR_MALFORMED;
          end else if (tok_cnt_q < TOK_FULL) begin
            tok_chars_d = {tok_chars_q[TOK_W-9:0], ch_i};
            tok_cnt_d   = tok_cnt_q + 3'd1;
          end else begin
            tok_cnt_d = TOK_OVER;
          end
        end
        default: err_d = ERR_MALFORMED;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      err_q       <= ERR_NONE;
      tok_chars_q <= '0;
      tok_cnt_q   <= '0;
      accum_q     <= '0;
      dest_q      <= '0;
      comp_q      <= '0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      tok_chars_q <= tok_chars_d;
      tok_cnt_q   <= tok_cnt_d;
      accum_q     <= accum_d;
      dest_q      <= dest_d;
      comp_q      <= comp_d;
    end
  end

  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ADDR |-> {4'b0, accum_q} <= ADDR_LIMIT)
    else $error("address accumulator above limit");

  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && ch_i == CH_NL |=> phase_q == PH_START && err_q == ERR_NONE && tok_cnt_q == '0)
    else $error("line state not cleared after newline");

  a_tok_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_cnt_q <= TOK_OVER)
    else $error("token count out of range");

endmodule

// ----- rtl/assembly_line_encoder.sv -----
// Top level of the assembly line encoder: input register, line core, result register.
// Depends on ale_pkg and ale_line_core.
//
// Usage: feed source text one byte per transfer on in_valid_i / in_stall_o / ch_i.
// A newline byte closes the line; an instruction line then yields one transfer on
// out_valid_o / out_stall_i carrying machine_word_o and status_o. Empty and
// comment-only lines yield nothing. Spaces and carriage returns are ignored.
// Status 0 is ok, 1 is a malformed line or unknown mnemonic, 2 an address above
// 2^15 - 1; the word is 0 whenever status is not 0.
// Throughput: one character per cycle unless a held result is stalled.
// The input register feeds the line core, which updates its state as each byte
// steps; a newline loads the result register, and out_valid_o is high once the
// result register holds the line's result.
// Reset clears the line state and the valid flags of both registers; the first
// byte after reset starts a new line.
// When the receiver stalls, the result holds; the input register still takes a
// byte while the result register is empty or draining, and in_stall_o rises only
// when both are full.
module assembly_line_encoder
  import ale_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] machine_word_o,
  output logic [1:0]  status_o
);

  logic        in_vld_q;
  logic [7:0]  ch_q;
  logic        out_vld_q;
  logic [15:0] word_q;
  status_e     status_q;
  logic        advance;
  logic        step;
  line_res_t   res;

  assign advance    = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !advance;
  assign step       = in_vld_q && advance;

  ale_line_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .ch_i   (ch_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_vld_q <= in_valid_i;
      if (advance) out_vld_q <= step && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) ch_q <= ch_i;
    if (step && res.emit) begin
      word_q   <= res.word;
      status_q <= res.status;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign machine_word_o = word_q;
  assign status_o       = status_q;

  a_err_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> machine_word_o == 16'h0)
    else $error("nonzero word with error status");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_MALFORMED ||
                     status_o == ST_OVERFLOW))
    else $error("illegal status code");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free stage");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q)
    else $error("stalled result dropped");

endmodule
